[design/bpa_pkg.sv]
// Shared types and codes for the buddy page allocator.
package bpa_pkg;

  typedef enum logic [1:0] {
    KIND_INNER = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_ALLOC = 2'd2
  } kind_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_MEMORY = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

endpackage

[design/bpa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/buddy_page_allocator.sv]
// Buddy page allocator: a sequencer over one page-table RAM and per-order list heads.
// An allocate sizes the request, finds a list, pops its head and fixes a link, splits the block
// as needed, then writes the left half. A free checks the page, merges with free buddies, then
// pushes the block. One word is in flight at a time; the result is held until the master side
// takes it, and the next word is accepted the cycle after. After reset the table is swept.
module buddy_page_allocator #(
  parameter int NUM_PAGES  = 1024,
  parameter int NUM_ORDERS = 6,
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // request_size[19:0], page_index[29:20], zero pad
  input  logic        s_tuser,  // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // granted_page[9:0], block_order[12:10], zero pad
  output logic [1:0]  m_tuser   // status
);

  localparam int PW   = $clog2(NUM_PAGES);
  localparam int OW   = $clog2(NUM_ORDERS);
  localparam int CNTW = $clog2(NUM_ORDERS + 1);
  localparam int TOP  = NUM_ORDERS - 1;
  localparam int TOPP = 1 << TOP;
  localparam int BW   = $clog2(PAGE_BYTES) + NUM_ORDERS + 1;
  localparam int CW   = (BW > 20) ? BW : 20;

  typedef struct packed {
    logic          vld;
    logic [PW-1:0] pg;
  } link_t;

  typedef struct packed {
    bpa_pkg::kind_t kind;
    logic [OW-1:0]  order;
    link_t          prev;
    link_t          next;
  } entry_t;

  typedef struct packed {
    logic          vld;
    logic          is_next;
    logic [PW-1:0] addr;
    link_t         link;
  } fix_t;

  typedef enum logic [17:0] {
    S_INIT     = 18'b000000000000000001,
    S_IDLE     = 18'b000000000000000010,
    S_SIZE     = 18'b000000000000000100,
    S_FIND     = 18'b000000000000001000,
    S_POP_RD   = 18'b000000000000010000,
    S_POP_USE  = 18'b000000000000100000,
    S_SPLIT    = 18'b000000000001000000,
    S_SPLIT_WR = 18'b000000000010000000,
    S_LEFT_WR  = 18'b000000000100000000,
    S_FREE_RD  = 18'b000000001000000000,
    S_FREE_CHK = 18'b000000010000000000,
    S_MERGE    = 18'b000000100000000000,
    S_BUD_USE  = 18'b000001000000000000,
    S_HI_WR    = 18'b000010000000000000,
    S_PUSH_WR  = 18'b000100000000000000,
    S_FIX_RD   = 18'b001000000000000000,
    S_FIX_WR   = 18'b010000000000000000,
    S_DONE     = 18'b100000000000000000
  } state_t;

  localparam link_t NONE = '{vld: 1'b0, pg: '0};

  state_t state, state_next, ret, ret_next;
  logic [PW-1:0]   init_cnt, init_cnt_next;
  link_t           heads [NUM_ORDERS];
  link_t           heads_next [NUM_ORDERS];
  fix_t            f0, f0_next, f1, f1_next;
  logic [19:0]     size, size_next;
  logic [CW-1:0]   bsize, bsize_next;
  logic [CNTW-1:0] req, req_next, t, t_next;
  logic [PW-1:0]   cur, cur_next, left, left_next, rgt, rgt_next, bud, bud_next;
  logic [9:0]      res_page, res_page_next;
  logic [2:0]      res_order, res_order_next;
  logic [1:0]      res_status, res_status_next;

  logic          wr_en;
  logic [PW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;

  logic [PW:0]   right_sum, buddy_x;
  logic [CNTW-1:0] tm1;
  entry_t        init_entry, fix_entry;

  bpa_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(NUM_PAGES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign tm1       = t - CNTW'(1);
  assign right_sum = {1'b0, left} + ((PW+1)'(1) << tm1);
  assign buddy_x   = {1'b0, cur} ^ ((PW+1)'(1) << t);

  always_comb begin
    init_entry = '{kind: bpa_pkg::KIND_INNER, order: '0, prev: NONE, next: NONE};
    if ((32'(init_cnt) % TOPP) == 0 && 32'(init_cnt) + TOPP <= NUM_PAGES) begin
      init_entry.kind    = bpa_pkg::KIND_FREE;
      init_entry.order   = OW'(TOP);
      init_entry.prev    = '{vld: (init_cnt != '0), pg: PW'(32'(init_cnt) - TOPP)};
      init_entry.next    = '{vld: (32'(init_cnt) + 2 * TOPP <= NUM_PAGES),
                             pg: PW'(32'(init_cnt) + TOPP)};
    end
    fix_entry = rd_data;
    if (f0.is_next) begin
      fix_entry.next = f0.link;
    end else begin
      fix_entry.prev = f0.link;
    end
  end

  always_comb begin
    state_next      = state;
    ret_next        = ret;
    init_cnt_next   = init_cnt;
    heads_next      = heads;
    f0_next         = f0;
    f1_next         = f1;
    size_next       = size;
    bsize_next      = bsize;
    req_next        = req;
    t_next          = t;
    cur_next        = cur;
    left_next       = left;
    rgt_next        = rgt;
    bud_next        = bud;
    res_page_next   = res_page;
    res_order_next  = res_order;
    res_status_next = res_status;
    wr_en           = 1'b0;
    wr_addr         = cur;
    wr_data         = init_entry;
    rd_addr         = cur;

    unique case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_cnt;
        wr_data = init_entry;
        if (32'(init_cnt) == NUM_PAGES - 1) begin
          state_next = S_IDLE;
        end else begin
          init_cnt_next = init_cnt + PW'(1);
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          size_next       = s_tdata[19:0];
          cur_next        = PW'(s_tdata[29:20]);
          req_next        = '0;
          bsize_next      = CW'(PAGE_BYTES);
          res_page_next   = '0;
          res_order_next  = '0;
          res_status_next = bpa_pkg::ST_OK;
          if (s_tuser == bpa_pkg::OP_ALLOC) begin
            state_next = S_SIZE;
          end else if (32'(s_tdata[29:20]) < NUM_PAGES) begin
            state_next = S_FREE_RD;
          end else begin
            res_status_next = bpa_pkg::ST_BAD_FREE;
            state_next      = S_DONE;
          end
        end
      end
      S_SIZE: begin
        if (req == CNTW'(NUM_ORDERS)) begin
          res_status_next = bpa_pkg::ST_TOO_LARGE;
          state_next      = S_DONE;
        end else if (bsize < CW'(size)) begin
          req_next   = req + CNTW'(1);
          bsize_next = bsize << 1;
        end else begin
          t_next     = req;
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        if (t == CNTW'(NUM_ORDERS)) begin
          res_status_next = bpa_pkg::ST_NO_MEMORY;
          state_next      = S_DONE;
        end else if (heads[t[OW-1:0]].vld) begin
          left_next  = heads[t[OW-1:0]].pg;
          state_next = S_POP_RD;
        end else begin
          t_next = t + CNTW'(1);
        end
      end
      S_POP_RD: begin
        rd_addr    = left;
        state_next = S_POP_USE;
      end
      S_POP_USE: begin
        heads_next[t[OW-1:0]] = rd_data.next;
        if (rd_data.next.vld) begin
          f0_next    = '{vld: 1'b1, is_next: 1'b0, addr: rd_data.next.pg, link: NONE};
          ret_next   = S_SPLIT;
          state_next = S_FIX_RD;
        end else begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (t > req) begin
          t_next   = tm1;
          rgt_next = right_sum[PW-1:0];
          if (32'(right_sum) < NUM_PAGES) begin
            state_next = S_SPLIT_WR;
          end
        end else begin
          state_next = S_LEFT_WR;
        end
      end
      S_SPLIT_WR: begin
        wr_en   = 1'b1;
        wr_addr = rgt;
        wr_data = '{kind: bpa_pkg::KIND_FREE, order: t[OW-1:0], prev: NONE,
                    next: heads[t[OW-1:0]]};
        heads_next[t[OW-1:0]] = '{vld: 1'b1, pg: rgt};
        if (heads[t[OW-1:0]].vld) begin
          f0_next    = '{vld: 1'b1, is_next: 1'b0, addr: heads[t[OW-1:0]].pg,
                         link: '{vld: 1'b1, pg: rgt}};
          ret_next   = S_SPLIT;
          state_next = S_FIX_RD;
        end else begin
          state_next = S_SPLIT;
        end
      end
      S_LEFT_WR: begin
        wr_en          = 1'b1;
        wr_addr        = left;
        wr_data        = '{kind: bpa_pkg::KIND_ALLOC, order: req[OW-1:0], prev: NONE,
                           next: NONE};
        res_page_next  = 10'(left);
        res_order_next = 3'(req);
        state_next     = S_DONE;
      end
      S_FREE_RD: begin
        rd_addr    = cur;
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (rd_data.kind != bpa_pkg::KIND_ALLOC) begin
          res_status_next = bpa_pkg::ST_BAD_FREE;
          state_next      = S_DONE;
        end else begin
          t_next     = CNTW'(rd_data.order);
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        rd_addr  = buddy_x[PW-1:0];
        bud_next = buddy_x[PW-1:0];
        if (t < CNTW'(TOP) && 32'(buddy_x) < NUM_PAGES) begin
          state_next = S_BUD_USE;
        end else begin
          state_next = S_PUSH_WR;
        end
      end
      S_BUD_USE: begin
        if (rd_data.kind == bpa_pkg::KIND_FREE && rd_data.order == t[OW-1:0]) begin
          if (rd_data.prev.vld) begin
            f0_next = '{vld: 1'b1, is_next: 1'b1, addr: rd_data.prev.pg,
                        link: rd_data.next};
            f1_next = '{vld: rd_data.next.vld, is_next: 1'b0, addr: rd_data.next.pg,
                        link: rd_data.prev};
          end else begin
            heads_next[t[OW-1:0]] = rd_data.next;
            f0_next = '{vld: rd_data.next.vld, is_next: 1'b0, addr: rd_data.next.pg,
                        link: rd_data.prev};
          end
          ret_next   = S_HI_WR;
          state_next = S_FIX_RD;
        end else begin
          state_next = S_PUSH_WR;
        end
      end
      S_HI_WR: begin
        wr_en      = 1'b1;
        wr_addr    = (bud > cur) ? bud : cur;
        wr_data    = '{kind: bpa_pkg::KIND_INNER, order: '0, prev: NONE, next: NONE};
        cur_next   = (bud < cur) ? bud : cur;
        t_next     = t + CNTW'(1);
        state_next = S_MERGE;
      end
      S_PUSH_WR: begin
        wr_en   = 1'b1;
        wr_addr = cur;
        wr_data = '{kind: bpa_pkg::KIND_FREE, order: t[OW-1:0], prev: NONE,
                    next: heads[t[OW-1:0]]};
        heads_next[t[OW-1:0]] = '{vld: 1'b1, pg: cur};
        res_page_next  = 10'(cur);
        res_order_next = 3'(t);
        if (heads[t[OW-1:0]].vld) begin
          f0_next    = '{vld: 1'b1, is_next: 1'b0, addr: heads[t[OW-1:0]].pg,
                         link: '{vld: 1'b1, pg: cur}};
          ret_next   = S_DONE;
          state_next = S_FIX_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FIX_RD: begin
        rd_addr = f0.addr;
        if (f0.vld) begin
          state_next = S_FIX_WR;
        end else begin
          state_next = ret;
        end
      end
      S_FIX_WR: begin
        wr_en       = 1'b1;
        wr_addr     = f0.addr;
        wr_data     = fix_entry;
        f0_next     = f1;
        f1_next.vld = 1'b0;
        state_next  = S_FIX_RD;
      end
      S_DONE: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      ret      <= S_IDLE;
      init_cnt <= '0;
      f0.vld   <= 1'b0;
      f1.vld   <= 1'b0;
      for (int k = 0; k < NUM_ORDERS; k++) begin
        if (k == TOP && TOPP <= NUM_PAGES) begin
          heads[k] <= '{vld: 1'b1, pg: '0};
        end else begin
          heads[k] <= NONE;
        end
      end
    end else begin
      state    <= state_next;
      ret      <= ret_next;
      init_cnt <= init_cnt_next;
      f0       <= f0_next;
      f1       <= f1_next;
      heads    <= heads_next;
    end
    size       <= size_next;
    bsize      <= bsize_next;
    req        <= req_next;
    t          <= t_next;
    cur        <= cur_next;
    left       <= left_next;
    rgt        <= rgt_next;
    bud        <= bud_next;
    res_page   <= res_page_next;
    res_order  <= res_order_next;
    res_status <= res_status_next;
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_DONE);
  assign m_tdata  = {3'b000, res_order, res_page};
  assign m_tuser  = res_status;

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("ready and valid both high");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != bpa_pkg::ST_OK) |-> (m_tdata[12:0] == 13'd0))
    else $error("error word carries a page or order");
  a_init: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("ready during table sweep");

endmodule

[test/tb.sv]
// Testbench for the buddy page allocator with a behavioral predictor of every result word.
`timescale 1ns / 1ps
module tb;

  localparam int NPAGES = 1024;
  localparam int NORD   = 6;
  localparam int TOPO   = NORD - 1;
  localparam int PGB    = 4096;
  localparam int NONE   = -1;

  typedef struct packed {
    logic [9:0] page;
    logic [2:0] order;
    logic [1:0] status;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  buddy_page_allocator i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  bpa_pkg::kind_t pg_kind [NPAGES];
  int     pg_ord  [NPAGES];
  int     pg_prev [NPAGES];
  int     pg_next [NPAGES];
  int     heads   [NORD];
  reply_t replies_due[$];
  int     held_blocks[$];
  int     errors;
  int     send_idle;
  int     recv_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void model_reset();
    int last;
    last = NONE;
    for (int i = 0; i < NPAGES; i++) begin
      pg_kind[i] = bpa_pkg::KIND_INNER;
      pg_ord[i] = 0;
      pg_prev[i] = NONE;
      pg_next[i] = NONE;
    end
    for (int o = 0; o < NORD; o++) heads[o] = NONE;
    for (int i = 0; i + (1 << TOPO) <= NPAGES; i += 1 << TOPO) begin
      pg_kind[i] = bpa_pkg::KIND_FREE;
      pg_ord[i] = TOPO;
      pg_prev[i] = last;
      if (last != NONE) pg_next[last] = i;
      else heads[TOPO] = i;
      last = i;
    end
  endfunction

  function automatic void push_free(int p, int o);
    pg_prev[p] = NONE;
    pg_next[p] = heads[o];
    if (heads[o] != NONE) pg_prev[heads[o]] = p;
    heads[o] = p;
  endfunction

  function automatic void unlink_free(int p, int o);
    int pv, nx;
    pv = pg_prev[p];
    nx = pg_next[p];
    if (pv != NONE) pg_next[pv] = nx;
    else heads[o] = nx;
    if (nx != NONE) pg_prev[nx] = pv;
    pg_prev[p] = NONE;
    pg_next[p] = NONE;
  endfunction

  function automatic reply_t predict_alloc(int unsigned size);
    reply_t r;
    int req, t, left;
    r = '0;
    if (size > PGB * (1 << TOPO)) begin
      r.status = bpa_pkg::ST_TOO_LARGE;
      return r;
    end
    req = 0;
    while ((PGB << req) < size) req++;
    t = req;
    while (t < NORD && heads[t] == NONE) t++;
    if (t >= NORD) begin
      r.status = bpa_pkg::ST_NO_MEMORY;
      return r;
    end
    left = heads[t];
    unlink_free(left, t);
    while (t > req) begin
      t--;
      if (left + (1 << t) < NPAGES) begin
        pg_kind[left + (1 << t)] = bpa_pkg::KIND_FREE;
        pg_ord[left + (1 << t)] = t;
        push_free(left + (1 << t), t);
      end
    end
    pg_kind[left] = bpa_pkg::KIND_ALLOC;
    pg_ord[left] = req;
    r.page = 10'(left);
    r.order = 3'(req);
    r.status = bpa_pkg::ST_OK;
    return r;
  endfunction

  function automatic reply_t predict_free(int idx);
    reply_t r;
    int o, bud;
    r = '0;
    if (idx >= NPAGES || pg_kind[idx] != bpa_pkg::KIND_ALLOC) begin
      r.status = bpa_pkg::ST_BAD_FREE;
      return r;
    end
    o = pg_ord[idx];
    forever begin
      bud = idx ^ (1 << o);
      if (o < TOPO && bud < NPAGES && pg_kind[bud] == bpa_pkg::KIND_FREE &&
          pg_ord[bud] == o) begin
        unlink_free(bud, o);
        pg_kind[bud] = bpa_pkg::KIND_INNER;
        pg_ord[bud] = 0;
        pg_kind[idx] = bpa_pkg::KIND_INNER;
        pg_ord[idx] = 0;
        if (bud < idx) idx = bud;
        o++;
      end else begin
        pg_kind[idx] = bpa_pkg::KIND_FREE;
        pg_ord[idx] = o;
        push_free(idx, o);
        break;
      end
    end
    r.page = 10'(idx);
    r.order = 3'(o);
    r.status = bpa_pkg::ST_OK;
    return r;
  endfunction

  task automatic send_word(logic op, logic [19:0] size, logic [9:0] idx);
    reply_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    if (op == bpa_pkg::OP_ALLOC) r = predict_alloc(size);
    else r = predict_free(idx);
    replies_due.push_back(r);
    if (op == bpa_pkg::OP_ALLOC && r.status == bpa_pkg::ST_OK) held_blocks.push_back(r.page);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {2'b00, idx, size};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic free_held(int unsigned k);
    int p;
    k = k % held_blocks.size();
    p = held_blocks[k];
    held_blocks.delete(k);
    send_word(bpa_pkg::OP_FREE, 20'($urandom), 10'(p));
  endtask

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    reply_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.page = m_tdata[9:0];
      got.order = m_tdata[12:10];
      got.status = m_tuser;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected word page=%0d order=%0d status=%0d",
                 $time, got.page, got.order, got.status);
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (got.page !== want.page) begin
          $display("%0t: page expected %0d actual %0d", $time, want.page, got.page);
          errors++;
        end
        if (got.order !== want.order) begin
          $display("%0t: order expected %0d actual %0d", $time, want.order, got.order);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_word(bpa_pkg::OP_ALLOC, 20'd0, 10'd0);
    send_word(bpa_pkg::OP_ALLOC, 20'd1, 10'h3FF);
    send_word(bpa_pkg::OP_ALLOC, 20'd4096, 10'd0);
    send_word(bpa_pkg::OP_ALLOC, 20'd4097, 10'd0);
    send_word(bpa_pkg::OP_ALLOC, 20'd131072, 10'd0);
    send_word(bpa_pkg::OP_ALLOC, 20'd131073, 10'd0);
    send_word(bpa_pkg::OP_ALLOC, 20'hFFFFF, 10'd0);
    send_word(bpa_pkg::OP_FREE, 20'hFFFFF, 10'd1);
    send_word(bpa_pkg::OP_FREE, 20'd0, 10'h3FF);
    send_word(bpa_pkg::OP_FREE, 20'd0, 10'd0);
    send_word(bpa_pkg::OP_FREE, 20'd0, 10'd0);
    while (held_blocks.size() > 0) free_held(0);
    for (int i = 0; i < 33; i++) send_word(bpa_pkg::OP_ALLOC, 20'd131072, 10'd0);
    send_word(bpa_pkg::OP_ALLOC, 20'd0, 10'd0);
    while (held_blocks.size() > 0) free_held($urandom);
  endtask

  task automatic test_random(int n);
    int c;
    logic [19:0] sz;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(99);
      case ($urandom_range(3))
        0: sz = 20'($urandom_range(4096));
        1: sz = 20'($urandom_range(32768));
        2: sz = 20'($urandom_range(131072));
        default: sz = 20'($urandom);
      endcase
      if (c < 45) send_word(bpa_pkg::OP_ALLOC, sz, 10'($urandom));
      else if (c < 90 && held_blocks.size() > 0) free_held($urandom);
      else send_word(bpa_pkg::OP_FREE, 20'($urandom), 10'($urandom));
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (replies_due.size() > 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    send_idle = 26;
    recv_idle = 78;
    model_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(420);
    send_idle = 78;
    recv_idle = 26;
    test_random(420);
    send_idle = 0;
    recv_idle = 0;
    test_random(420);
    while (held_blocks.size() > 0) free_held($urandom);
    drain();
    if (errors == 0 && replies_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
